/* sv/dfsq_pkg.sv */
// Package with the shared codes and control/status types of the deduplicating queue.
`timescale 1ns / 1ps
package dfsq_pkg;

   // Request command codes.
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_CHANGED  = 2'd0;
   localparam logic [1:0] ST_NOCHANGE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;       // capture the incoming request, restart the scan
      logic       scan_en;    // step the search through the stored pairs
      logic       shift_en;   // step the gap-closing copy after a removal
      logic       append;     // write the request pair at the tail
      logic       dec_count;  // one pair fewer
      logic       set_status; // latch status_code
      logic [1:0] status_code;
      logic       out_load;   // capture the response payload
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cmd_remove; // captured request is a removal
      logic hit;        // the compared slot matches the request pair
      logic scan_end;   // every occupied slot compared, no match
      logic shift_end;  // gap closed
      logic full;       // no free slot
   } stat_type;

endpackage

/* sv/dfsq_req_if.sv */
// Request channel interface: valid/ready handshake with the request payload.
`timescale 1ns / 1ps
interface dfsq_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] action_id;
   logic signed [31:0] action_arg;

   modport source (output valid, output cmd, output action_id, output action_arg,
                   input ready);
   modport sink (input valid, input cmd, input action_id, input action_arg,
                 output ready);
endinterface

/* sv/dfsq_rsp_if.sv */
// Response channel interface: valid/ready handshake with the response payload.
`timescale 1ns / 1ps
interface dfsq_rsp_if;
   logic        valid;
   logic        ready;
   logic        head_valid;
   logic [15:0] head_action;
   logic signed [31:0] head_arg;
   logic [1:0]  status;
   logic [4:0]  occupancy;

   modport source (output valid, output head_valid, output head_action,
                   output head_arg, output status, output occupancy, input ready);
   modport sink (input valid, input head_valid, input head_action,
                 input head_arg, input status, input occupancy, output ready);
endinterface

/* sv/dfsq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dfsq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/dfsq_datapath.sv */
// Datapath: request latch, slot memory, scan and shift pointers, head copy and response register.
`timescale 1ns / 1ps
module dfsq_datapath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_cmd,
   input  logic [15:0]          req_action_id,
   input  logic signed [31:0]   req_action_arg,
   input  dfsq_pkg::ctrl_type   ctrl,
   output dfsq_pkg::stat_type   stat,
   output logic                 rsp_head_valid,
   output logic [15:0]          rsp_head_action,
   output logic signed [31:0]   rsp_head_arg,
   output logic [1:0]           rsp_status,
   output logic [4:0]           rsp_occupancy
);
   import dfsq_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = 48;
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   // Captured request.
   logic          cmd_ff;
   logic [PW-1:0] key_ff;

   // Occupancy, pointers and head copy.
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pend_idx_ff, pend_idx_in;
   logic [PW-1:0] head_ff, head_in;
   logic [1:0]    status_ff;

   // Response payload registers.
   logic          out_hv_ff;
   logic [PW-1:0] out_head_ff;
   logic [1:0]    out_status_ff;
   logic [4:0]    out_occ_ff;

   // Memory ports.
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [PW-1:0] ram_wdata;
   logic [PW-1:0] ram_rdata;
   logic [CW-1:0] shift_dst;
   logic          issue;
   logic          hit;
   logic [31:0]   count_wide;

   dfsq_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ptr_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   // Compare and progress flags.
   assign hit       = pend_ff && (ram_rdata == key_ff);
   assign issue     = (ptr_ff < count_ff);
   assign shift_dst = pend_idx_ff - 1'b1;

   assign stat.cmd_remove = (cmd_ff == CMD_REMOVE);
   assign stat.hit        = hit;
   assign stat.scan_end   = !pend_ff && !issue;
   assign stat.shift_end  = !pend_ff && !issue;
   assign stat.full       = (count_ff >= DEPTH_C);

   // Memory write: append at the tail, or copy one slot down while closing a gap.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = count_ff[AW-1:0];
      ram_wdata = key_ff;
      if (ctrl.append) begin
         ram_we = 1'b1;
      end else if (ctrl.shift_en && pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = shift_dst[AW-1:0];
         ram_wdata = ram_rdata;
      end
   end

   // Pointer, read-tracking, count and head updates.
   always_comb begin
      ptr_in      = ptr_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      if (ctrl.load) begin
         ptr_in  = '0;
         pend_in = 1'b0;
      end else if (ctrl.scan_en && hit) begin
         // Match found: the copy starts from the slot after it.
         ptr_in  = pend_idx_ff + 1'b1;
         pend_in = 1'b0;
      end else if (ctrl.scan_en || ctrl.shift_en) begin
         pend_in     = issue;
         pend_idx_in = ptr_ff;
         if (issue) begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
      if (ctrl.shift_en && pend_ff && (shift_dst == '0)) begin
         head_in = ram_rdata;
      end
      if (ctrl.append) begin
         count_in = count_ff + 1'b1;
         if (count_ff == '0) begin
            head_in = key_ff;
         end
      end
      if (ctrl.dec_count) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      head_ff     <= head_in;
      if (ctrl.load) begin
         cmd_ff <= req_cmd;
         key_ff <= {req_action_id, req_action_arg};
      end
      if (ctrl.set_status) begin
         status_ff <= ctrl.status_code;
      end
   end

   assign count_wide = 32'(count_ff);

   // Response register, loaded once the step has settled.
   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         out_hv_ff     <= (count_ff != '0);
         out_head_ff   <= (count_ff != '0) ? head_ff : '0;
         out_status_ff <= status_ff;
         out_occ_ff    <= count_wide[4:0];
      end
   end

   assign rsp_head_valid  = out_hv_ff;
   assign rsp_head_action = out_head_ff[47:32];
   assign rsp_head_arg    = out_head_ff[31:0];
   assign rsp_status      = out_status_ff;
   assign rsp_occupancy   = out_occ_ff;

endmodule

/* sv/dfsq_ctrl.sv */
// Controller: sequences the search, gap closing and response of each request.
`timescale 1ns / 1ps
module dfsq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  dfsq_pkg::stat_type  stat,
   output dfsq_pkg::ctrl_type  ctrl
);
   import dfsq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            ctrl.scan_en = 1'b1;
            if (stat.hit) begin
               if (stat.cmd_remove) begin
                  state_in = S_SHIFT;
               end else begin
                  ctrl.set_status  = 1'b1;
                  ctrl.status_code = ST_NOCHANGE;
                  state_in         = S_RESP;
               end
            end else if (stat.scan_end) begin
               ctrl.set_status = 1'b1;
               state_in        = S_RESP;
               if (stat.cmd_remove) begin
                  ctrl.status_code = ST_NOCHANGE;
               end else if (stat.full) begin
                  ctrl.status_code = ST_FULL;
               end else begin
                  ctrl.append      = 1'b1;
                  ctrl.status_code = ST_CHANGED;
               end
            end
         end
         S_SHIFT: begin
            ctrl.shift_en = 1'b1;
            if (stat.shift_end) begin
               ctrl.dec_count   = 1'b1;
               ctrl.set_status  = 1'b1;
               ctrl.status_code = ST_CHANGED;
               state_in         = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               ctrl.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response valid: set on load, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/dedup_fifo_scheduler_queue_top.sv */
// Each request is paced by the one-slot-per-cycle scan and, for a hit removal, by the copy that
// closes the gap, both through one read port.
// Throughput: one request at a time; the next is taken in the cycle after the response is
// registered, while that response waits in the output register.
// Reset (synchronous, active high) empties the queue and clears the handshakes; slot contents
// are left as they are and are never read before being written.
`timescale 1ns / 1ps
module dedup_fifo_scheduler_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   dfsq_req_if.sink    req_chan,
   dfsq_rsp_if.source  rsp_chan
);
   import dfsq_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   dfsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   dfsq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_chan.cmd),
      .req_action_id   (req_chan.action_id),
      .req_action_arg  (req_chan.action_arg),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_head_valid  (rsp_chan.head_valid),
      .rsp_head_action (rsp_chan.head_action),
      .rsp_head_arg    (rsp_chan.head_arg),
      .rsp_status      (rsp_chan.status),
      .rsp_occupancy   (rsp_chan.occupancy)
   );

endmodule
